[sv/nspbt_pkg.sv]
`timescale 1ns / 1ps

package nspbt_pkg;

  // Default sizes
  localparam int unsigned NumBuffersDef = 2;
  localparam int unsigned PageBitsDef   = 12;
  localparam int unsigned BlockBitsDef  = 16;
  localparam int unsigned TimeBitsDef   = 24;

  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_PROG  = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_READ  = 2'd1,
    OP_PROG  = 2'd2,
    OP_ERASE = 2'd3
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_READ_TIME  = 3'd0,
    CFG_PROG_TIME  = 3'd1,
    CFG_ERASE_TIME = 3'd2,
    CFG_HIT_TIME   = 3'd3,
    CFG_BUF_EN     = 3'd4
  } cfg_idx_e;

  // Control handed from the front end to the timer
  typedef struct packed {
    logic fire;
    cmd_e cmd;
    logic hit;
  } ctl_t;

endpackage

[sv/nspbt_tags.sv]
`timescale 1ns / 1ps

// Page buffer tag store: parallel lookup, round-robin fill, erase invalidate.
module nspbt_tags #(
  parameter int unsigned NUM_BUFFERS = nspbt_pkg::NumBuffersDef,
  parameter int unsigned PAGE_BITS   = nspbt_pkg::PageBitsDef,
  parameter int unsigned BLOCK_BITS  = nspbt_pkg::BlockBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  nspbt_pkg::cmd_e       cmd_i,
  input  logic [PAGE_BITS-1:0]  page_i,
  input  logic [BLOCK_BITS-1:0] block_i,
  input  logic                  enable_i,
  output logic                  hit_o
);

  localparam int unsigned PtrW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(NUM_BUFFERS - 1);

  logic [NUM_BUFFERS-1:0] valid_q, valid_d;
  logic [PAGE_BITS-1:0]   page_q  [NUM_BUFFERS];
  logic [BLOCK_BITS-1:0]  block_q [NUM_BUFFERS];
  logic [PtrW-1:0]        ptr_q, ptr_d;
  logic [NUM_BUFFERS-1:0] match;
  logic                   fill;

  always_comb begin
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      match[i] = valid_q[i] && (page_q[i] == page_i) && (block_q[i] == block_i);
    end
  end

  assign hit_o = enable_i && (|match);

  assign fill = fire_i && enable_i &&
                ((cmd_i == nspbt_pkg::CMD_PROG) ||
                 ((cmd_i == nspbt_pkg::CMD_READ) && !hit_o));

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (fire_i && (cmd_i == nspbt_pkg::CMD_ERASE)) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        if (valid_q[i] && (block_q[i] == block_i)) begin
          valid_d[i] = 1'b0;
        end
      end
    end
    if (fill) begin
      valid_d[ptr_q] = 1'b1;
      ptr_d = (ptr_q == PtrLast) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  // tags carry no reset, only read behind a valid bit
  always_ff @(posedge clk_i) begin
    if (fill) begin
      page_q[ptr_q]  <= page_i;
      block_q[ptr_q] <= block_i;
    end
  end

endmodule

[sv/nspbt_timer.sv]
`timescale 1ns / 1ps

// Operation state and countdown timer.
module nspbt_timer #(
  parameter int unsigned TIME_BITS = nspbt_pkg::TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nspbt_pkg::ctl_t      ctl_i,
  input  logic [TIME_BITS-1:0] read_time_i,
  input  logic [TIME_BITS-1:0] prog_time_i,
  input  logic [TIME_BITS-1:0] erase_time_i,
  input  logic [TIME_BITS-1:0] hit_time_i,
  output nspbt_pkg::op_e       op_status_o,
  output logic [TIME_BITS-1:0] ticks_o,
  output logic                 done_o
);

  nspbt_pkg::op_e       op_q, op_d;
  logic [TIME_BITS-1:0] ticks_q, ticks_d;
  logic [TIME_BITS-1:0] ticks_dec;
  logic                 done_d;

  assign ticks_dec = (ticks_q != '0) ? ticks_q - 1'b1 : ticks_q;

  // next state
  always_comb begin
    op_d    = op_q;
    ticks_d = ticks_q;
    done_d  = 1'b0;
    if (ctl_i.fire) begin
      unique case (ctl_i.cmd)
        nspbt_pkg::CMD_READ: begin
          op_d    = nspbt_pkg::OP_READ;
          ticks_d = ctl_i.hit ? hit_time_i : read_time_i;
        end
        nspbt_pkg::CMD_PROG: begin
          op_d    = nspbt_pkg::OP_PROG;
          ticks_d = prog_time_i;
        end
        nspbt_pkg::CMD_ERASE: begin
          op_d    = nspbt_pkg::OP_ERASE;
          ticks_d = erase_time_i;
        end
        nspbt_pkg::CMD_TICK: begin
          if (op_q != nspbt_pkg::OP_IDLE) begin
            ticks_d = ticks_dec;
            if (ticks_dec == '0) begin
              op_d   = nspbt_pkg::OP_IDLE;
              done_d = 1'b1;
            end
          end
        end
        default: begin
          op_d = op_q;
        end
      endcase
    end
  end

  // outputs: the state as it stands after this beat
  always_comb begin
    op_status_o = op_d;
    ticks_o     = ticks_d;
    done_o      = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= nspbt_pkg::OP_IDLE;
      ticks_q <= '0;
    end else begin
      op_q    <= op_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

[sv/nand_subarray_page_buffer_timer_top.sv]
`timescale 1ns / 1ps

// NAND sub-array model with page buffers and an operation timer. Each input
// beat is a command (read, program, erase) or a tick; each gives exactly one
// result beat carrying the buffer hit flag, the operation state, the ticks
// left and a done flag. Throughput is one beat per cycle while the result
// channel does not stall. An accepted beat goes into the input register, then
// one pass through the tag compare and timer update loads the result register
// once the result slot is free or draining. The result register lets the
// next command be taken while a result still waits. A new command replaces
// any running operation. Timing registers and the buffer enable must be
// written through the configuration port only while no beat is in flight;
// the block itself does not enforce this. After reset the times are zero and
// the buffers are enabled and empty.
module nand_subarray_page_buffer_timer_top #(
  parameter int unsigned NUM_BUFFERS = nspbt_pkg::NumBuffersDef,
  parameter int unsigned PAGE_BITS   = nspbt_pkg::PageBitsDef,
  parameter int unsigned BLOCK_BITS  = nspbt_pkg::BlockBitsDef,
  parameter int unsigned TIME_BITS   = nspbt_pkg::TimeBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [nspbt_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [TIME_BITS-1:0]             cfg_wdata_i,
  // command channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       cmd_i,
  input  logic [PAGE_BITS-1:0]             page_i,
  input  logic [BLOCK_BITS-1:0]            block_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             buffer_hit_o,
  output logic [1:0]                       op_status_o,
  output logic [TIME_BITS-1:0]             ticks_left_o,
  output logic                             done_res_o
);

  // configuration registers
  logic [TIME_BITS-1:0] read_time_q, prog_time_q, erase_time_q, hit_time_q;
  logic                 buf_en_q;

  // input register
  logic                  in_valid_q;
  nspbt_pkg::cmd_e       cmd_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [BLOCK_BITS-1:0] block_q;

  // result register
  logic                 out_valid_q;
  logic                 hit_res_q;
  logic [1:0]           status_q;
  logic [TIME_BITS-1:0] ticks_q;
  logic                 done_q;

  logic                 in_accept;
  logic                 fire;
  logic                 hit;
  nspbt_pkg::ctl_t      ctl;
  nspbt_pkg::op_e       op_next;
  logic [TIME_BITS-1:0] ticks_next;
  logic                 done_next;

  // Process the held beat whenever the result slot is free or draining.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_time_q  <= '0;
      prog_time_q  <= '0;
      erase_time_q <= '0;
      hit_time_q   <= '0;
      buf_en_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nspbt_pkg::CFG_READ_TIME:  read_time_q  <= cfg_wdata_i;
        nspbt_pkg::CFG_PROG_TIME:  prog_time_q  <= cfg_wdata_i;
        nspbt_pkg::CFG_ERASE_TIME: erase_time_q <= cfg_wdata_i;
        nspbt_pkg::CFG_HIT_TIME:   hit_time_q   <= cfg_wdata_i;
        nspbt_pkg::CFG_BUF_EN:     buf_en_q     <= cfg_wdata_i[0];
        default:                   buf_en_q     <= buf_en_q; // unknown index
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= nspbt_pkg::cmd_e'(cmd_i);
      page_q  <= page_i;
      block_q <= block_i;
    end
  end

  nspbt_tags #(
    .NUM_BUFFERS(NUM_BUFFERS),
    .PAGE_BITS  (PAGE_BITS),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_tags (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .cmd_i   (cmd_q),
    .page_i  (page_q),
    .block_i (block_q),
    .enable_i(buf_en_q),
    .hit_o   (hit)
  );

  // hit only matters for reads; the tag block already gates on enable
  assign ctl.fire = fire;
  assign ctl.cmd  = cmd_q;
  assign ctl.hit  = hit && (cmd_q == nspbt_pkg::CMD_READ);

  nspbt_timer #(
    .TIME_BITS(TIME_BITS)
  ) u_timer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .read_time_i (read_time_q),
    .prog_time_i (prog_time_q),
    .erase_time_i(erase_time_q),
    .hit_time_i  (hit_time_q),
    .op_status_o (op_next),
    .ticks_o     (ticks_next),
    .done_o      (done_next)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_res_q <= ctl.hit;
      status_q  <= op_next;
      ticks_q   <= ticks_next;
      done_q    <= done_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign buffer_hit_o = hit_res_q;
  assign op_status_o  = status_q;
  assign ticks_left_o = ticks_q;
  assign done_res_o   = done_q;

  // A finishing tick always leaves the block idle with the timer at zero.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |->
      (op_status_o == nspbt_pkg::OP_IDLE) && (ticks_left_o == '0))
    else $error("done result without idle state");

  // A buffer hit is only ever reported on a read.
  a_hit_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buffer_hit_o |-> op_status_o == nspbt_pkg::OP_READ)
    else $error("buffer hit outside a read");

  // Processing a beat always leaves a result waiting next cycle.
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed beat lost its result");

  // Upstream is held back only when a beat is parked and the result slot is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without cause");

endmodule

[dv/nand_subarray_page_buffer_timer_top_tb.sv]
`timescale 1ns / 1ps

// Sub-array testbench: a queue-fed driver offers command beats, a monitor
// checks every result beat against an in-line predictor of the page buffers
// and the operation timer. Timing registers change only between phases, once
// the block has drained.
module nand_subarray_page_buffer_timer_top_tb;
  import nspbt_pkg::*;

  localparam int unsigned PageBits  = PageBitsDef;
  localparam int unsigned BlockBits = BlockBitsDef;
  localparam int unsigned TimeBits  = TimeBitsDef;
  localparam int unsigned NumSlots  = NumBuffersDef;

  localparam logic [PageBits-1:0]  PageMax  = {PageBits{1'b1}};
  localparam logic [BlockBits-1:0] BlockMax = {BlockBits{1'b1}};
  localparam logic [TimeBits-1:0]  TimeMax  = {TimeBits{1'b1}};

  // Register indexes above the last defined one; writes there are dropped
  localparam int unsigned CfgIdxSpareLo = 5;
  localparam int unsigned CfgIdxTop     = (1 << CfgIdxBits) - 1;

  localparam int unsigned PoolSize     = 4;
  localparam int unsigned RandPhases   = 4;
  localparam int unsigned PhaseBeats   = 245;
  localparam int unsigned DrainCycles  = 6;    // settling margin after the queues drain
  localparam int unsigned HoldAfter    = 150;  // results before the long hold-off
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 300000;

  typedef struct {
    cmd_e                 cmd;
    logic [PageBits-1:0]  page;
    logic [BlockBits-1:0] blk;
  } subarray_cmd_t;

  typedef struct {
    logic                hit;
    op_e                 status;
    logic [TimeBits-1:0] ticks;
    logic                done;
  } subarray_res_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx   = '0;
  logic [TimeBits-1:0]   cfg_wdata = '0;

  logic                 in_valid  = 1'b0;
  cmd_e                 cmd_drv   = CMD_TICK;
  logic [PageBits-1:0]  page_drv  = '0;
  logic [BlockBits-1:0] blk_drv   = '0;
  logic                 in_stall;

  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                buffer_hit;
  logic [1:0]          op_status;
  logic [TimeBits-1:0] ticks_left;
  logic                done_res;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  nand_subarray_page_buffer_timer_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd_drv),
    .page_i       (page_drv),
    .block_i      (blk_drv),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .buffer_hit_o (buffer_hit),
    .op_status_o  (op_status),
    .ticks_left_o (ticks_left),
    .done_res_o   (done_res)
  );

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the timing registers, the page buffers and the
  // timer. Reset values as the block comes out of reset.
  // ---------------------------------------------------------------------------
  logic [TimeBits-1:0] t_read  = '0;
  logic [TimeBits-1:0] t_prog  = '0;
  logic [TimeBits-1:0] t_erase = '0;
  logic [TimeBits-1:0] t_hit   = '0;
  logic                buf_en  = 1'b1;

  op_e                  cur_op    = OP_IDLE;
  logic [TimeBits-1:0]  cur_ticks = '0;
  logic                 slot_valid [NumSlots] = '{default: 1'b0};
  logic [PageBits-1:0]  slot_page  [NumSlots];
  logic [BlockBits-1:0] slot_blk   [NumSlots];
  int unsigned          fill_ptr  = 0;

  // Round-robin fill of the next page buffer
  function automatic void fill_slot(logic [PageBits-1:0] pg, logic [BlockBits-1:0] blk);
    slot_valid[fill_ptr] = 1'b1;
    slot_page[fill_ptr]  = pg;
    slot_blk[fill_ptr]   = blk;
    fill_ptr = (fill_ptr + 1) % NumSlots;
  endfunction

  function automatic subarray_res_t step_subarray(cmd_e c, logic [PageBits-1:0] pg,
                                                  logic [BlockBits-1:0] blk);
    subarray_res_t r;
    r.hit  = 1'b0;
    r.done = 1'b0;
    case (c)
      CMD_READ: begin
        cur_op = OP_READ;
        if (buf_en) begin
          foreach (slot_valid[i])
            if (slot_valid[i] && slot_page[i] == pg && slot_blk[i] == blk) r.hit = 1'b1;
        end
        if (r.hit) begin
          cur_ticks = t_hit;
        end else begin
          cur_ticks = t_read;
          if (buf_en) fill_slot(pg, blk);
        end
      end
      CMD_PROG: begin
        cur_op    = OP_PROG;
        cur_ticks = t_prog;
        if (buf_en) fill_slot(pg, blk);
      end
      CMD_ERASE: begin
        // erase drops every buffer of its block, enabled or not
        cur_op    = OP_ERASE;
        cur_ticks = t_erase;
        foreach (slot_valid[i])
          if (slot_valid[i] && slot_blk[i] == blk) slot_valid[i] = 1'b0;
      end
      default: begin
        // tick: idle stays idle; zero-time ops finish on their first tick
        if (cur_op != OP_IDLE) begin
          if (cur_ticks != '0) cur_ticks = cur_ticks - 1'b1;
          if (cur_ticks == '0) begin
            cur_op = OP_IDLE;
            r.done = 1'b1;
          end
        end
      end
    endcase
    r.status = cur_op;
    r.ticks  = cur_ticks;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  subarray_cmd_t cmd_queue[$];
  subarray_res_t expected_results[$];
  int unsigned   n_errors     = 0;
  int unsigned   results_seen = 0;
  logic [31:0]   cycle_count  = '0;
  logic          calm;

  // A quarter of the time neither side idles, so back-to-back beats occur
  assign calm = (cycle_count[9:8] == 2'b11);

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Mostly no wait, some short waits, the odd long one
  function automatic int unsigned pick_wait(logic quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes beats from cmd_queue; predicts on every accepted beat
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    subarray_cmd_t nxt;
    logic          taken;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) expected_results.push_back(step_subarray(cmd_drv, page_drv, blk_drv));
      // payload is held untouched while stalled
      if (!in_valid || taken) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (cmd_queue.size() != 0) begin
          nxt       = cmd_queue.pop_front();
          cmd_drv  <= nxt.cmd;
          page_drv <= nxt.page;
          blk_drv  <= nxt.blk;
          in_valid <= 1'b1;
          gap_left <= pick_wait(calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random back-pressure, plus one long hold-off part way into
  // the first random phase so the block fills and stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : res_stall
    int unsigned w;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HoldAfter) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      w = pick_wait(calm);
      out_stall  <= (w != 0);
      stall_left <= (w == 0) ? 0 : w - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : res_monitor
    subarray_res_t want;
    if (!rst_ni) begin
      results_seen <= 0;
    end else if (out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing predicted (hit %0b op %0d ticks %0d done %0b)",
                 $time, buffer_hit, op_status, ticks_left, done_res);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (buffer_hit !== want.hit) begin
          $display("%0t: buffer_hit expected %0b got %0b", $time, want.hit, buffer_hit);
          n_errors++;
        end
        if (op_status !== want.status) begin
          $display("%0t: op_status expected %0d got %0d", $time, want.status, op_status);
          n_errors++;
        end
        if (ticks_left !== want.ticks) begin
          $display("%0t: ticks_left expected %0d got %0d", $time, want.ticks, ticks_left);
          n_errors++;
        end
        if (done_res !== want.done) begin
          $display("%0t: done_res expected %0b got %0b", $time, want.done, done_res);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic [PageBits-1:0]  pool_page [PoolSize];
  logic [BlockBits-1:0] pool_blk  [PoolSize];

  task automatic push_cmd(cmd_e c, logic [PageBits-1:0] pg, logic [BlockBits-1:0] blk);
    subarray_cmd_t item;
    item.cmd  = c;
    item.page = pg;
    item.blk  = blk;
    cmd_queue.push_back(item);
  endtask

  // Register write; the shadow copy follows at once since nothing is in flight
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [TimeBits-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_READ_TIME:  t_read  = val;
      CFG_PROG_TIME:  t_prog  = val;
      CFG_ERASE_TIME: t_erase = val;
      CFG_HIT_TIME:   t_hit   = val;
      CFG_BUF_EN:     buf_en  = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_unused_reg();
    write_reg(CfgIdxBits'($urandom_range(CfgIdxSpareLo, CfgIdxTop)), TimeBits'($urandom));
  endtask

  // Wait until every beat has gone in and every result has come back
  task automatic settle();
    while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Mostly short times so ticks run operations out; now and then huge ones
  function automatic logic [TimeBits-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return TimeBits'($urandom_range(0, 5));
    if (r < 90) return TimeBits'($urandom);
    return TimeMax;
  endfunction

  task automatic randomise_timing();
    logic [TimeBits-1:0] en_word;
    en_word    = TimeBits'($urandom);
    en_word[0] = ($urandom_range(0, 3) != 0);
    write_reg(CFG_READ_TIME,  pick_time());
    write_reg(CFG_PROG_TIME,  pick_time());
    write_reg(CFG_ERASE_TIME, pick_time());
    write_reg(CFG_HIT_TIME,   pick_time());
    write_reg(CFG_BUF_EN,     en_word);
    if ($urandom_range(0, 1) != 0) write_unused_reg();
  endtask

  task automatic refresh_pool_entry(int unsigned k);
    pool_page[k] = PageBits'($urandom);
    pool_blk[k]  = BlockBits'($urandom);
    // first two entries share a block: page must matter on hits, erase hits both
    pool_blk[1]  = pool_blk[0];
  endtask

  // Addresses mostly from a small pool so reads hit and erases land on
  // buffered blocks; the rest fully random.
  task automatic queue_random_cmds(int unsigned n);
    subarray_cmd_t item;
    int unsigned   r;
    int unsigned   k;
    @(negedge clk_i);
    for (k = 0; k < PoolSize; k++) refresh_pool_entry(k);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35)      item.cmd = CMD_READ;
      else if (r < 55) item.cmd = CMD_PROG;
      else if (r < 65) item.cmd = CMD_ERASE;
      else             item.cmd = CMD_TICK;
      item.page = PageBits'($urandom);
      item.blk  = BlockBits'($urandom);
      if (item.cmd != CMD_TICK && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, PoolSize - 1);
        item.page = pool_page[k];
        item.blk  = pool_blk[k];
      end
      if ($urandom_range(0, 39) == 0) refresh_pool_entry($urandom_range(0, PoolSize - 1));
      cmd_queue.push_back(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: zero times, buffers on and empty
    @(negedge clk_i);
    push_cmd(CMD_TICK, PageBits'($urandom), BlockBits'($urandom));  // tick while idle
    push_cmd(CMD_READ, '0, '0);        // miss, zero time: busy until next tick
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_READ, '0, '0);        // now a hit
    settle();

    write_reg(CFG_READ_TIME,  TimeBits'(3));
    write_reg(CFG_PROG_TIME,  TimeBits'(5));
    write_reg(CFG_ERASE_TIME, TimeBits'(2));
    write_reg(CFG_HIT_TIME,   TimeBits'(1));
    write_reg(CFG_BUF_EN,     TimeBits'(1));
    write_unused_reg();

    @(negedge clk_i);
    push_cmd(CMD_READ,  PageMax, BlockMax);
    push_cmd(CMD_READ,  PageMax, BlockMax);      // hit, replaces running read
    push_cmd(CMD_TICK,  '0, '0);
    push_cmd(CMD_TICK,  PageMax, BlockMax);
    push_cmd(CMD_PROG,  12'hAAA, 16'h5555);
    push_cmd(CMD_READ,  12'hAAA, 16'h5555);      // hit during a program
    push_cmd(CMD_ERASE, 12'h555, 16'h5555);      // page field ignored
    push_cmd(CMD_READ,  12'hAAA, 16'h5555);      // miss after erase
    push_cmd(CMD_TICK,  12'h555, 16'hAAAA);
    push_cmd(CMD_TICK,  '0, '0);
    push_cmd(CMD_TICK,  '0, '0);
    settle();

    // Buffers off; only bit 0 of the written word counts
    write_reg(CFG_BUF_EN, TimeBits'(24'hFFFFFE));
    @(negedge clk_i);
    push_cmd(CMD_READ,  PageMax, BlockMax);
    push_cmd(CMD_PROG,  12'h555, 16'hAAAA);
    push_cmd(CMD_READ,  12'h555, 16'hAAAA);      // still a miss: nothing filled
    push_cmd(CMD_ERASE, '0, BlockMax);
    settle();

    // Largest times
    write_reg(CFG_READ_TIME,  TimeMax);
    write_reg(CFG_PROG_TIME,  TimeMax);
    write_reg(CFG_ERASE_TIME, TimeMax);
    write_reg(CFG_HIT_TIME,   TimeMax);
    write_reg(CFG_BUF_EN,     TimeBits'(1));
    @(negedge clk_i);
    push_cmd(CMD_READ,  12'h555, 16'hAAAA);
    push_cmd(CMD_TICK,  '0, '0);
    push_cmd(CMD_ERASE, PageMax, 16'hAAAA);
    push_cmd(CMD_TICK,  '0, '0);
    settle();

    repeat (RandPhases) begin
      randomise_timing();
      queue_random_cmds(PhaseBeats);
      settle();
    end

    if (n_errors == 0) begin
      $display("nand_subarray_page_buffer_timer_top_tb: PASS");
    end else begin
      $display("nand_subarray_page_buffer_timer_top_tb: FAIL");
    end
    $finish;
  end

  // Watchdog on the free-running cycle count
  initial begin : watchdog
    wait (cycle_count == CycleLimit);
    $display("%0t: timed out with %0d results outstanding", $time, expected_results.size());
    $display("nand_subarray_page_buffer_timer_top_tb: FAIL");
    $finish;
  end

endmodule
